>>> rtl/core/ppt_pkg.sv
// ----------------------------------------------------------------------------
// ppt_pkg: shared types and constants for the perfect power test
// Controller states, command and status bundles, field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package ppt_pkg;

    localparam int VALUE_WIDTH_DEF = 31;
    localparam int EXP_W           = 6;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CHECK  = 6'b000010,
        S_POWER  = 6'b000100,
        S_MUL    = 6'b001000,
        S_DECIDE = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture a new item, range = 1..value
        logic set_mid;    // new midpoint, acc = mid, count = 1
        logic mul;        // prod = acc * mid, count + 1
        logic take_prod;  // acc = prod
        logic go_hi;      // hi = mid - 1
        logic go_lo;      // lo = mid + 1
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic range_ok;   // lo <= hi
        logic more_mul;   // count < exponent
        logic prod_gt;    // product above value
        logic acc_eq;     // acc == value
        logic acc_gt;     // acc > value
    } t_status;

endpackage

`default_nettype wire

>>> rtl/core/ppt_dp.sv
// ----------------------------------------------------------------------------
// ppt_dp: search datapath
// Holds the search range, midpoint, running power and one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module ppt_dp #(
    parameter int VALUE_WIDTH = ppt_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic [VALUE_WIDTH-1:0]    i_value,
    input  wire logic [ppt_pkg::EXP_W-1:0] i_exponent,
    input  wire ppt_pkg::t_cmd             i_cmd,
    output ppt_pkg::t_status               o_status
);
    import ppt_pkg::*;

    localparam int W = VALUE_WIDTH;

    logic [W-1:0]     r_val;
    logic [EXP_W-1:0] r_exp;
    logic [W:0]       r_lo;   // one bit wider: lo may reach value + 1
    logic [W-1:0]     r_hi;
    logic [W-1:0]     r_mid;
    logic [W-1:0]     r_acc;
    logic [EXP_W-1:0] r_cnt;
    logic [2*W-1:0]   r_prod;

    logic [W:0]       w_diff;
    logic [W:0]       w_mid;

    assign w_diff = {1'b0, r_hi} - r_lo;
    assign w_mid  = r_lo + (w_diff >> 1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val <= i_value;
            r_exp <= i_exponent;
            r_lo  <= (W+1)'(1);
            r_hi  <= i_value;
        end
        if (i_cmd.set_mid) begin
            r_mid <= w_mid[W-1:0];
            r_acc <= w_mid[W-1:0];
            r_cnt <= EXP_W'(1);
        end
        if (i_cmd.mul) begin
            r_prod <= {{W{1'b0}}, r_acc} * {{W{1'b0}}, r_mid};
            r_cnt  <= r_cnt + EXP_W'(1);
        end
        if (i_cmd.take_prod) begin
            r_acc <= r_prod[W-1:0];
        end
        if (i_cmd.go_hi) begin
            r_hi <= r_mid - W'(1);
        end
        if (i_cmd.go_lo) begin
            r_lo <= {1'b0, r_mid} + (W+1)'(1);
        end
    end

    assign o_status.range_ok = (r_lo <= {1'b0, r_hi});
    assign o_status.more_mul = (r_cnt < r_exp);
    assign o_status.prod_gt  = (r_prod > {{W{1'b0}}, r_val});
    assign o_status.acc_eq   = (r_acc == r_val);
    assign o_status.acc_gt   = (r_acc > r_val);

endmodule

`default_nettype wire

>>> rtl/core/ppt_ctrl.sv
// ----------------------------------------------------------------------------
// ppt_ctrl: search sequencer
// Steps the binary search and the bounded power loop, issues the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ppt_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_out_free,
    input  wire ppt_pkg::t_status i_status,
    output logic                  o_in_ready,
    output ppt_pkg::t_cmd         o_cmd,
    output logic                  o_emit,
    output logic                  o_emit_val
);
    import ppt_pkg::*;

    t_state r_state, n_state;
    logic   r_hit, n_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hit   <= n_hit;
        end
    end

    always_comb begin
        n_state = r_state;
        n_hit   = r_hit;
        o_cmd   = '0;
        o_emit  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.range_ok) begin
                    o_cmd.set_mid = 1'b1;
                    n_state       = S_POWER;
                end else begin
                    n_hit   = 1'b0;
                    n_state = S_EMIT;
                end
            end
            S_POWER: begin
                if (i_status.more_mul) begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_MUL;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_MUL: begin
                // early exit once the running power passes the value
                if (i_status.prod_gt) begin
                    o_cmd.go_hi = 1'b1;
                    n_state     = S_CHECK;
                end else begin
                    o_cmd.take_prod = 1'b1;
                    n_state         = S_POWER;
                end
            end
            S_DECIDE: begin
                if (i_status.acc_eq) begin
                    n_hit   = 1'b1;
                    n_state = S_EMIT;
                end else if (i_status.acc_gt) begin
                    o_cmd.go_hi = 1'b1;
                    n_state     = S_CHECK;
                end else begin
                    o_cmd.go_lo = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_EMIT: begin
                if (i_out_free) begin
                    o_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_emit_val = r_hit;

endmodule

`default_nettype wire

>>> rtl/core/perfect_power_test.sv
// ----------------------------------------------------------------------------
// perfect_power_test: integer k-th root perfect power test
// Decides whether a value is an exact power of an integer base.
// ----------------------------------------------------------------------------
// Usage
//   Slave stream (i_s_axis_*): one transfer carries a value and an exponent.
//   Master stream (o_m_axis_*): one transfer per item carrying is_power.
//   The block binary-searches the base over 1..value. Each round does
//   up to exponent - 1 multiplications (none for an exponent of 0 or 1),
//   fewer when the running power passes the value and the round ends
//   early, over at most VALUE_WIDTH rounds.
//   The single shared VALUE_WIDTH x VALUE_WIDTH multiplier and its result
//   register set the pace. One item is in work at a time:
//   o_s_axis_tready is high only while the sequencer is idle.
//   The result sits in an output register, so the next item may be taken
//   while a result still waits. If the receiver stalls, the finished
//   search waits until the register frees.
//   Reset (synchronous, active low) returns the sequencer to idle and
//   drops o_m_axis_tvalid; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module perfect_power_test #(
    parameter  int VALUE_WIDTH = ppt_pkg::VALUE_WIDTH_DEF,
    localparam int IN_TDATA_W  = ((VALUE_WIDTH + ppt_pkg::EXP_W + 7) / 8) * 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // slave stream
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // tdata: value[VALUE_WIDTH-1:0], exponent[5:0], zero padding
    input  wire logic [IN_TDATA_W-1:0] i_s_axis_tdata,
    // master stream
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // tdata: is_power[0], zero padding
    output logic [7:0]                 o_m_axis_tdata
);
    import ppt_pkg::*;

    t_cmd    st_cmd;
    t_status st_status;

    logic r_out_valid;
    logic r_out_is_power;
    logic w_out_free;
    logic w_emit;
    logic w_emit_val;

    // the output register is free when empty or being drained this cycle
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    ppt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_out_free (w_out_free),
        .i_status   (st_status),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (st_cmd),
        .o_emit     (w_emit),
        .o_emit_val (w_emit_val)
    );

    ppt_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_value    (i_s_axis_tdata[VALUE_WIDTH-1:0]),
        .i_exponent (i_s_axis_tdata[VALUE_WIDTH+EXP_W-1:VALUE_WIDTH]),
        .i_cmd      (st_cmd),
        .o_status   (st_status)
    );

    // output register: valid is control, the result bit is payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_is_power <= w_emit_val;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'b0, r_out_is_power};

`ifndef SYNTHESIS
    // one item at a time: an accepted transfer makes the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted while an item is in work");

    // a result is never written over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> (!r_out_valid || i_m_axis_tready))
        else $error("result issued while the output register was full");

    // an issued result shows up on the master stream
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (o_m_axis_tvalid && o_m_axis_tdata[0] == $past(w_emit_val)))
        else $error("issued result missing on the master stream");

    // the datapath is only loaded from idle
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_cmd.load |-> (o_s_axis_tready && i_s_axis_tvalid))
        else $error("datapath loaded outside an input transfer");
`endif

endmodule

`default_nettype wire

>>> tb/sv/perfect_power_test_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perfect_power_test_tb: self-checking bench for the perfect power test
// Streams (value, exponent) queries into the block and checks each is_power
// flag against a local k-th root search, with random idle gaps from the sender
// and random back-pressure from the receiver.
// ----------------------------------------------------------------------------

module perfect_power_test_tb;

    import ppt_pkg::*;

    localparam int VW         = VALUE_WIDTH_DEF;
    localparam int IN_W       = ((VW + EXP_W + 7) / 8) * 8;
    localparam int IDLE_LIMIT = 20000;  // cycles with no transfer on either stream
    localparam int HOLD_CYC   = 400;    // long receiver hold-off
    localparam int HOLD_AT    = 200;    // ... begins once this many queries are in
    localparam int CALM_TAIL  = 80;     // last queries run with no idling
    localparam int TAIL_CYC   = 200;    // quiet time after the last flag
    localparam int N_RANDOM   = 925;

    typedef struct {
        bit [VW-1:0]    value;
        bit [EXP_W-1:0] exponent;
        bit             drain;    // sender waits for all flags before offering this one
    } power_query_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [IN_W-1:0]     i_s_axis_tdata = '0;   // value, exponent, zero padding
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [7:0]          o_m_axis_tdata;        // is_power, zero padding

    power_query_t pending_queries[$];
    bit           expected_flags[$];

    int  fail_count;
    int  queries_in;       // accepted input transfers
    int  total_queries;
    int  idle_pct;         // chance (percent) of starting an idle burst
    int  quiet_cycles;
    bit  in_fired;         // set at the rising edge, read by the driver
    int  src_gap;
    int  sink_gap;
    int  hold_left;
    bit  hold_done;

    perfect_power_test i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // base^exp, giving up as soon as the running product passes the limit.
    // An exponent of zero does no multiplication, so it acts as exponent one.
    // The product never gets past limit * base < 2^62, so 64 bits suffice.
    function automatic longint unsigned capped_power(longint unsigned base,
                                                     int unsigned exp,
                                                     longint unsigned limit);
        longint unsigned acc;
        acc = base;
        for (int unsigned i = 1; i < exp; i++) begin
            acc = acc * base;
            if (acc > limit)
                break;
        end
        return acc;
    endfunction

    // Binary search of the base over 1..value; zero leaves the range empty.
    function automatic bit is_exact_power(bit [VW-1:0] value, bit [EXP_W-1:0] exponent);
        longint unsigned v, lo, hi, mid, p;
        v  = value;
        lo = 1;
        hi = v;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            p   = capped_power(mid, exponent, v);
            if (p > v)
                hi = mid - 1;
            else if (p < v)
                lo = mid + 1;
            else
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [IN_W-1:0] pack_query(power_query_t q);
        logic [IN_W-1:0] d;
        d = '0;
        d[VW-1:0]        = q.value;
        d[VW+EXP_W-1:VW] = q.exponent;
        return d;
    endfunction

    task automatic log_mismatch(string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        fail_count++;
    endtask

    task automatic add_query(longint unsigned value, int unsigned exponent, bit drain);
        power_query_t q;
        q.value    = value[VW-1:0];
        q.exponent = exponent[EXP_W-1:0];
        q.drain    = drain;
        pending_queries = {pending_queries, q};
    endtask

    // ------------------------------------------------------------------------
    // Monitor: samples both streams at the rising edge, predicts on input
    // transfers, checks on output transfers, and keeps the watchdog.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        bit out_fired;
        bit want;
        if (i_rst_n) begin
            in_fired  = i_s_axis_tvalid && o_s_axis_tready;
            out_fired = o_m_axis_tvalid && i_m_axis_tready;

            if (in_fired) begin
                expected_flags = {expected_flags,
                    is_exact_power(i_s_axis_tdata[VW-1:0], i_s_axis_tdata[VW+EXP_W-1:VW])};
                queries_in++;
                // change the idling mix every 64 queries, including calm stretches
                if (queries_in % 64 == 0)
                    case ($urandom_range(0, 3))
                        0: idle_pct = 0;
                        1: idle_pct = 3;
                        2: idle_pct = 12;
                        default: idle_pct = 35;
                    endcase
                if (queries_in >= total_queries - CALM_TAIL)
                    idle_pct = 0;
            end

            if (out_fired) begin
                if (expected_flags.size() == 0) begin
                    log_mismatch($sformatf("flag transfer with nothing expected, tdata=%02h",
                                           o_m_axis_tdata));
                end else begin
                    want = expected_flags.pop_front();
                    if (o_m_axis_tdata[0] !== want)
                        log_mismatch($sformatf("is_power got %b want %b",
                                               o_m_axis_tdata[0], want));
                    if (o_m_axis_tdata[7:1] !== 7'd0)
                        log_mismatch($sformatf("padding got %02h want 00",
                                               o_m_axis_tdata[7:1]));
                end
            end

            if (in_fired || out_fired)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: offers queued queries on the falling edge. A query marked drain
    // is held back until every flag already owed has been received. No idle
    // bursts while the receiver is in its long hold-off, so the block backs up.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic            nxt_valid;
        logic [IN_W-1:0] nxt_data;
        power_query_t    q;
        if (i_rst_n) begin
            nxt_valid = i_s_axis_tvalid;
            nxt_data  = i_s_axis_tdata;
            if (in_fired)
                nxt_valid = 1'b0;
            if (!nxt_valid) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (pending_queries.size() > 0 &&
                             !(pending_queries[0].drain && expected_flags.size() > 0)) begin
                    q         = pending_queries.pop_front();
                    nxt_valid = 1'b1;
                    nxt_data  = pack_query(q);
                    if (hold_left == 0 && idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
                        src_gap = $urandom_range(1, 14);
                end
            end
            in_fired = 1'b0;
            i_s_axis_tvalid <= nxt_valid;
            i_s_axis_tdata  <= nxt_data;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts, plus one long hold-off part way in.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic rdy;
        if (i_rst_n) begin
            if (!hold_done && queries_in >= HOLD_AT) begin
                hold_left = HOLD_CYC;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
                if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
                    sink_gap = $urandom_range(1, 14);
            end
            i_m_axis_tready <= rdy;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        longint unsigned v, base, vmax;
        int unsigned     e, nbits, pick;

        fail_count   = 0;
        queries_in   = 0;
        idle_pct     = 10;
        quiet_cycles = 0;
        in_fired     = 1'b0;
        src_gap      = 0;
        sink_gap     = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        vmax         = (64'd1 << VW) - 1;

        // directed: zero, one, exponent zero/one/all-ones, full-scale value,
        // exact powers at the top of the range and their neighbours
        add_query(0, 1, 0);
        add_query(0, 63, 0);
        add_query(1, 1, 0);
        add_query(1, 63, 0);
        add_query(1, 0, 0);
        add_query(2, 1, 0);
        add_query(2, 2, 0);
        add_query(4, 2, 0);
        add_query(8, 3, 0);
        add_query(9, 3, 0);
        add_query(5, 0, 0);
        add_query(vmax, 0, 0);
        add_query(vmax, 1, 0);
        add_query(vmax, 2, 0);
        add_query(vmax, 31, 0);
        add_query(vmax, 63, 1);           // sender waits for the results so far
        add_query(64'h4000_0000, 30, 0);  // 2^30
        add_query(64'h4000_0000, 2, 0);   // 32768^2
        add_query(64'h4000_0000, 31, 0);
        add_query(64'h4000_0000, 60, 0);
        add_query(2147395600, 2, 0);      // 46340^2, largest square
        add_query(2147395601, 2, 0);
        add_query(1162261467, 19, 0);     // 3^19
        add_query(2146689000, 3, 0);      // 1290^3
        add_query(1977326743, 11, 0);     // 7^11

        // random: mostly exact powers (and their neighbours) so the search
        // ends on a hit, the rest arbitrary values of mixed magnitude
        for (int n = 0; n < N_RANDOM; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                e     = $urandom_range(1, 30);
                nbits = $urandom_range(1, VW / e);
                base  = ({$urandom, $urandom} & ((64'd1 << nbits) - 1)) | (64'd1 << (nbits - 1));
                v     = base;
                for (int unsigned k = 1; k < e; k++)
                    v = v * base;
                case ($urandom_range(0, 5))
                    0: v = v + 1;
                    1: v = v - 1;
                    default: ;
                endcase
                add_query(v & vmax, e, n == 500);
            end else if (pick < 90) begin
                nbits = $urandom_range(1, VW);
                add_query({$urandom, $urandom} & ((64'd1 << nbits) - 1),
                          $urandom_range(0, 63), n == 500);
            end else begin
                add_query({$urandom, $urandom} & vmax, $urandom_range(1, 63), n == 500);
            end
        end
        total_queries = pending_queries.size();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_queries.size() > 0 || i_s_axis_tvalid || expected_flags.size() > 0)
            @(posedge i_clk);
        repeat (TAIL_CYC) @(posedge i_clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/ppt_pkg.sv
rtl/core/ppt_dp.sv
rtl/core/ppt_ctrl.sv
rtl/core/perfect_power_test.sv
tb/sv/perfect_power_test_tb.sv
